FILE: design/gjs_pkg.sv
`default_nettype none
package gjs_pkg;
    localparam int ORDER = 3;
    localparam int COLS = ORDER + 1;
    localparam int CELLS = ORDER * COLS;
    localparam int FRAC_BITS = 16;
    localparam int INT_FRAC = 24;
    localparam int VW = 48;
    localparam int AW = 4;
    localparam logic signed [VW-1:0] MAX48 = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MIN48 = {1'b1, {(VW-1){1'b0}}};
    localparam logic [63:0] CAP48 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] CAP32 = 64'h0000_0000_7FFF_FFFF;

    typedef logic signed [VW-1:0] val_t;

    typedef struct packed {
        logic        go;
        logic [VW-1:0] a_mag;
        logic [VW-1:0] b_mag;
        logic [VW-1:0] p_mag;
        logic        neg;
        logic        sol;
    } div_req_t;

    function automatic logic [VW-1:0] mag(input val_t v);
        mag = v[VW-1] ? (~v + 1'b1) : v;
    endfunction
endpackage
`default_nettype wire

FILE: design/gjs_muldiv.sv
`default_nettype none
// Shared multiply-divide unit: one exact 96-bit product is formed over
// four 24x24 partial products, then a restoring divider retires one
// quotient bit per cycle with saturation.
module gjs_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gjs_pkg::div_req_t req,
    output logic                 done,
    output gjs_pkg::val_t        quot
);
    localparam int PW = 2 * gjs_pkg::VW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  pp_reg;
    logic [6:0]  bit_reg;
    logic [PW-1:0] num_reg;
    logic [gjs_pkg::VW:0] rem_reg;
    logic [63:0] q_reg;
    logic        over_reg;
    logic [gjs_pkg::VW-1:0] a_reg, b_reg, d_reg;
    logic        neg_reg, sol_reg;
    logic [23:0] pa, pb;
    logic [47:0] pprod;
    logic [gjs_pkg::VW:0] rsh;
    logic        qb;
    logic [63:0] qn, cap;
    gjs_pkg::val_t res;

    assign cap = sol_reg ? (neg_reg ? gjs_pkg::CAP32 + 64'd1 : gjs_pkg::CAP32)
                         : (neg_reg ? gjs_pkg::CAP48 + 64'd1 : gjs_pkg::CAP48);

    always_comb
    begin
        pa = pp_reg[1] ? a_reg[47:24] : a_reg[23:0];
        pb = pp_reg[0] ? b_reg[47:24] : b_reg[23:0];
        pprod = pa * pb;
        rsh = {rem_reg[gjs_pkg::VW-1:0], num_reg[PW-1]};
        qb = (rsh >= {1'b0, d_reg});
        qn = {q_reg[62:0], qb};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req.go) state_next = S_MUL;
            S_MUL:  if (pp_reg == 3'd3) state_next = S_DIV;
            S_DIV:  if (bit_reg == 7'd0) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                a_reg <= req.a_mag;
                b_reg <= req.b_mag;
                d_reg <= req.p_mag;
                neg_reg <= req.neg;
                sol_reg <= req.sol;
                pp_reg <= 3'd0;
                num_reg <= '0;
            end
            S_MUL:
            begin
                num_reg <= num_reg + ({{(PW-48){1'b0}}, pprod}
                           << (7'(pp_reg[1]) * 7'd24 + 7'(pp_reg[0]) * 7'd24));
                pp_reg <= pp_reg + 3'd1;
                bit_reg <= 7'(PW - 1);
                rem_reg <= '0;
                q_reg <= '0;
                over_reg <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg <= qb ? rsh - {1'b0, d_reg} : rsh;
                num_reg <= {num_reg[PW-2:0], 1'b0};
                bit_reg <= bit_reg - 7'd1;
                if (!over_reg)
                begin
                    q_reg <= qn;
                    if (qn > cap) over_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res = over_reg ? gjs_pkg::val_t'(cap) : gjs_pkg::val_t'(q_reg);
        quot = neg_reg ? -res : res;
        done = (state_reg == S_DONE);
    end
endmodule
`default_nettype wire

FILE: design/gauss_jordan_solver_3x3.sv
`default_nettype none
// Loads twelve Q16.16 coefficients row by row, one per transfer, then
// solves by Gauss-Jordan elimination with partial pivoting and emits three
// Q16.16 solutions on consecutive strobed cycles that cannot be stalled.
// busy is high from the cycle after the twelfth transfer and drops in the
// cycle that carries the last result. A nonsingular solve runs 21
// multiply-divides (18 elimination terms and 3 solutions) through the single
// shared unit, whose divider retires one quotient bit per cycle; a system
// with zero pivots skips their divides and finishes sooner.
module gauss_jordan_solver_3x3 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] coeff_value,
    input  wire logic               start_system,
    output logic                    strobe,
    output logic signed [31:0]      solution_value,
    output logic [1:0]              unknown_index,
    output logic                    singular,
    output logic                    last_result
);
    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PIVK  = 4'd1;
    localparam logic [3:0] S_SWAP  = 4'd2;
    localparam logic [3:0] S_ROWC  = 4'd3;
    localparam logic [3:0] S_FAC   = 4'd4;
    localparam logic [3:0] S_RDAI  = 4'd5;
    localparam logic [3:0] S_RDRC  = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_SOLD  = 4'd8;
    localparam logic [3:0] S_SOLN  = 4'd9;
    localparam logic [3:0] S_SOLW  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_PIVR  = 4'd12;
    localparam logic [3:0] S_PIVC  = 4'd13;

    gjs_pkg::val_t mem [gjs_pkg::CELLS];
    logic [gjs_pkg::AW-1:0] load_reg;
    logic [3:0] state_reg;
    logic [1:0] i_reg, r_reg, c_reg, k_reg, best_reg;
    logic [1:0] sc_reg;
    logic       sing_reg;
    gjs_pkg::val_t rd_reg, piv_reg, fac_reg, aic_reg, best_v_reg;
    logic signed [31:0] sol_reg [gjs_pkg::ORDER];
    logic [gjs_pkg::AW-1:0] rd_addr, wr_addr;
    gjs_pkg::val_t wr_data;
    logic       wr_en;
    logic       acc;
    logic [gjs_pkg::AW-1:0] slot;
    gjs_pkg::div_req_t req;
    logic       done;
    gjs_pkg::val_t quot;
    logic signed [gjs_pkg::VW:0] diff;
    gjs_pkg::val_t subv;

    function automatic logic [gjs_pkg::AW-1:0] addr(input logic [1:0] r, input logic [1:0] c);
        addr = gjs_pkg::AW'(r) * gjs_pkg::AW'(gjs_pkg::COLS) + gjs_pkg::AW'(c);
    endfunction

    assign acc = start && !busy;
    assign busy = (state_reg != S_LOAD);
    assign slot = (start_system || load_reg >= gjs_pkg::AW'(gjs_pkg::CELLS)) ? '0 : load_reg;

    gjs_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(req), .done(done), .quot(quot));

    always_comb
    begin
        diff = {rd_reg[gjs_pkg::VW-1], rd_reg} - {quot[gjs_pkg::VW-1], quot};
        if (diff > $signed({1'b0, gjs_pkg::MAX48})) subv = gjs_pkg::MAX48;
        else if (diff < $signed({1'b1, gjs_pkg::MIN48})) subv = gjs_pkg::MIN48;
        else subv = diff[gjs_pkg::VW-1:0];
    end

    // Memory address, write selection and multiply-divide request per state.
    always_comb
    begin
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        req = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                wr_en = acc;
                wr_addr = slot;
                wr_data = gjs_pkg::val_t'({{16{coeff_value[31]}}, coeff_value} <<<
                          (gjs_pkg::INT_FRAC - gjs_pkg::FRAC_BITS));
            end
            S_PIVK: rd_addr = addr(i_reg, i_reg);
            S_PIVR: rd_addr = addr(r_reg, i_reg);
            S_PIVC: rd_addr = addr(best_reg, c_reg);
            S_SWAP:
            begin
                rd_addr = addr(i_reg, c_reg);
                wr_en = (sc_reg != 2'd0);
                wr_addr = (sc_reg == 2'd1) ? addr(best_reg, c_reg) : addr(i_reg, c_reg);
                wr_data = (sc_reg == 2'd1) ? rd_reg : aic_reg;
            end
            S_FAC: rd_addr = addr(r_reg, i_reg);
            S_RDAI: rd_addr = addr(i_reg, c_reg);
            S_RDRC:
            begin
                rd_addr = addr(r_reg, c_reg);
                req.go = 1'b1;
                req.a_mag = gjs_pkg::mag(aic_reg);
                req.b_mag = gjs_pkg::mag(fac_reg);
                req.p_mag = gjs_pkg::mag(piv_reg);
                req.neg = (aic_reg[gjs_pkg::VW-1] ^ fac_reg[gjs_pkg::VW-1])
                          ^ piv_reg[gjs_pkg::VW-1];
            end
            S_DIVW:
            begin
                rd_addr = addr(r_reg, c_reg);
                wr_en = done;
                wr_addr = addr(r_reg, c_reg);
                wr_data = subv;
            end
            S_SOLD: rd_addr = addr(k_reg, k_reg);
            S_SOLN: rd_addr = addr(k_reg, 2'(gjs_pkg::ORDER));
            S_SOLW:
            begin
                req.go = (piv_reg != '0) && (sc_reg == 2'd0);
                req.a_mag = gjs_pkg::mag(rd_reg);
                req.b_mag = gjs_pkg::VW'(1) << gjs_pkg::FRAC_BITS;
                req.p_mag = gjs_pkg::mag(piv_reg);
                req.neg = rd_reg[gjs_pkg::VW-1] ^ piv_reg[gjs_pkg::VW-1];
                req.sol = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            load_reg <= '0;
            sing_reg <= 1'b0;
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                    if (acc)
                    begin
                        if (slot == gjs_pkg::AW'(gjs_pkg::CELLS - 1))
                        begin
                            load_reg <= '0;
                            state_reg <= S_PIVK;
                            i_reg <= '0;
                            r_reg <= '0;
                            sing_reg <= 1'b0;
                            sc_reg <= '0;
                        end
                        else load_reg <= slot + gjs_pkg::AW'(1);
                    end
                // Scan the column below the pivot. A row whose entry is larger than
                // the current pivot is swapped up at once, then the scan goes on.
                S_PIVK:
                begin
                    sc_reg <= 2'd0;
                    if (i_reg == 2'(gjs_pkg::ORDER - 1))
                    begin
                        r_reg <= i_reg;
                        state_reg <= S_FAC;
                    end
                    else
                    begin
                        r_reg <= i_reg + 2'd1;
                        state_reg <= S_PIVR;
                    end
                end
                S_PIVR:
                begin
                    if (sc_reg == 2'd0)
                    begin
                        best_v_reg <= rd_reg;
                        sc_reg <= 2'd1;
                    end
                    else if (sc_reg == 2'd1)
                    begin
                        if (gjs_pkg::mag(rd_reg) > gjs_pkg::mag(best_v_reg))
                        begin
                            best_v_reg <= rd_reg;
                            best_reg <= r_reg;
                            c_reg <= '0;
                            state_reg <= S_PIVC;
                        end
                        else if (r_reg == 2'(gjs_pkg::ORDER - 1))
                        begin
                            sc_reg <= 2'd0;
                            r_reg <= i_reg;
                            state_reg <= S_FAC;
                        end
                        else
                        begin
                            r_reg <= r_reg + 2'd1;
                            sc_reg <= 2'd2;
                        end
                    end
                    else sc_reg <= 2'd1;
                end
                // Swap row best and row i, one column at a time.
                S_PIVC:
                begin
                    state_reg <= S_SWAP;
                    sc_reg <= 2'd0;
                end
                S_SWAP:
                begin
                    if (sc_reg == 2'd0)
                    begin
                        aic_reg <= rd_reg;
                        sc_reg <= 2'd1;
                    end
                    else if (sc_reg == 2'd1)
                    begin
                        sc_reg <= 2'd2;
                    end
                    else
                    begin
                        if (c_reg == 2'(gjs_pkg::ORDER))
                        begin
                            c_reg <= '0;
                            if (r_reg == 2'(gjs_pkg::ORDER - 1))
                            begin
                                sc_reg <= 2'd0;
                                r_reg <= i_reg;
                                state_reg <= S_FAC;
                            end
                            else
                            begin
                                sc_reg <= 2'd2;
                                r_reg <= r_reg + 2'd1;
                                state_reg <= S_PIVR;
                            end
                        end
                        else
                        begin
                            sc_reg <= 2'd0;
                            c_reg <= c_reg + 2'd1;
                            state_reg <= S_PIVC;
                        end
                    end
                end
                // Load pivot then the factor of each other row.
                S_FAC:
                begin
                    if (sc_reg == 2'd0)
                    begin
                        r_reg <= i_reg;
                        sc_reg <= 2'd1;
                    end
                    else if (sc_reg == 2'd1)
                    begin
                        piv_reg <= rd_reg;
                        if (rd_reg == '0)
                        begin
                            sing_reg <= 1'b1;
                            sc_reg <= 2'd0;
                            if (i_reg == 2'(gjs_pkg::ORDER - 1))
                            begin
                                k_reg <= '0;
                                state_reg <= S_SOLD;
                            end
                            else
                            begin
                                i_reg <= i_reg + 2'd1;
                                state_reg <= S_PIVK;
                            end
                        end
                        else
                        begin
                            sc_reg <= 2'd2;
                            r_reg <= (i_reg == 2'd0) ? 2'd1 : 2'd0;
                        end
                    end
                    else if (sc_reg == 2'd2)
                    begin
                        sc_reg <= 2'd3;
                    end
                    else
                    begin
                        fac_reg <= rd_reg;
                        c_reg <= i_reg;
                        state_reg <= S_RDAI;
                        sc_reg <= 2'd0;
                    end
                end
                S_RDAI:
                begin
                    if (sc_reg == 2'd0) sc_reg <= 2'd1;
                    else
                    begin
                        aic_reg <= rd_reg;
                        sc_reg <= 2'd0;
                        state_reg <= S_RDRC;
                    end
                end
                S_RDRC: state_reg <= S_DIVW;
                S_DIVW:
                    if (done)
                    begin
                        if (c_reg == 2'(gjs_pkg::ORDER))
                        begin
                            if (r_reg == 2'(gjs_pkg::ORDER - 1) ||
                                (r_reg == 2'(gjs_pkg::ORDER - 2) &&
                                 i_reg == 2'(gjs_pkg::ORDER - 1)))
                            begin
                                sc_reg <= 2'd0;
                                if (i_reg == 2'(gjs_pkg::ORDER - 1))
                                begin
                                    k_reg <= '0;
                                    state_reg <= S_SOLD;
                                end
                                else
                                begin
                                    i_reg <= i_reg + 2'd1;
                                    state_reg <= S_PIVK;
                                end
                            end
                            else
                            begin
                                r_reg <= (r_reg + 2'd1 == i_reg) ? r_reg + 2'd2
                                                                 : r_reg + 2'd1;
                                sc_reg <= 2'd2;
                                state_reg <= S_FAC;
                            end
                        end
                        else
                        begin
                            c_reg <= c_reg + 2'd1;
                            state_reg <= S_RDAI;
                        end
                    end
                S_SOLD:
                begin
                    state_reg <= S_SOLN;
                end
                S_SOLN:
                begin
                    piv_reg <= rd_reg;
                    sc_reg <= 2'd0;
                    state_reg <= S_SOLW;
                end
                S_SOLW:
                begin
                    if (piv_reg == '0)
                    begin
                        sing_reg <= 1'b1;
                        sol_reg[k_reg] <= '0;
                    end
                    else if (sc_reg == 2'd0) sc_reg <= 2'd1;
                    else if (done) sol_reg[k_reg] <= quot[31:0];
                    if (piv_reg == '0 || (sc_reg != 2'd0 && done))
                    begin
                        if (k_reg == 2'(gjs_pkg::ORDER - 1))
                        begin
                            k_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            state_reg <= S_SOLD;
                        end
                    end
                end
                S_OUT:
                begin
                    strobe <= 1'b1;
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'(gjs_pkg::ORDER - 1)) state_reg <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            solution_value <= sol_reg[k_reg];
            unknown_index <= k_reg;
            singular <= sing_reg;
            last_result <= (k_reg == 2'(gjs_pkg::ORDER - 1));
        end
    end

    // A result strobe must come while busy or in the cycle after an output-phase cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy || $past(state_reg) == S_OUT)
        else $error("result outside output phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_result |-> unknown_index == 2'(gjs_pkg::ORDER - 1))
        else $error("last result index wrong");
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && $past(strobe) && !$past(last_result) |->
        unknown_index == $past(unknown_index) + 2'd1)
        else $error("result order broken");
endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
    typedef struct {
        logic signed [31:0] coeff;
        logic               sys;
        logic               drain;
    } coeff_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         idx;
        logic               sing;
        logic               last;
    } solution_t;

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] coeff_value = '0;
    logic start_system = 1'b0;
    wire logic busy, strobe, singular, last_result;
    wire logic signed [31:0] solution_value;
    wire logic [1:0] unknown_index;

    coeff_item_t pending_coeffs[$];
    solution_t   expected_solutions[$];
    longint      matrix[0:gjs_pkg::ORDER-1][0:gjs_pkg::COLS-1];
    int          fill_count = 0;
    int          errors = 0;
    int          coeffs_sent = 0;
    int          solutions_seen = 0;
    int          singular_seen_count = 0;
    int          quiet_cycles = 0;

    gauss_jordan_solver_3x3 DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coeff_value(coeff_value), .start_system(start_system), .strobe(strobe),
        .solution_value(solution_value), .unknown_index(unknown_index),
        .singular(singular), .last_result(last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // (a*b)/p with the quotient magnitude truncated and capped before the sign goes back on.
    function automatic longint scaled_quotient(input longint a, input longint b,
                                               input longint p, input logic [63:0] cap);
        logic         neg;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  lim;
        neg = ((a < 0) != (b < 0)) != (p < 0);
        lim = neg ? cap + 64'd1 : cap;
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        quo = prod / {64'd0, magnitude(p)};
        if (quo > {64'd0, lim})
            quo = {64'd0, lim};
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic longint sat_sub48(input longint x, input longint y);
        longint d;
        d = x - y;
        if (d > longint'(gjs_pkg::MAX48))
            return longint'(gjs_pkg::MAX48);
        if (d < longint'(gjs_pkg::MIN48))
            return longint'(gjs_pkg::MIN48);
        return d;
    endfunction

    task automatic absorb_coeff(input logic signed [31:0] c, input logic sys);
        longint    piv, factor, t, d;
        longint    tmp;
        logic      sing;
        solution_t s;
        if (sys)
            fill_count = 0;
        matrix[fill_count / gjs_pkg::COLS][fill_count % gjs_pkg::COLS] = longint'(c) * 256;
        fill_count++;
        if (fill_count < gjs_pkg::CELLS)
            return;
        fill_count = 0;
        sing = 1'b0;
        for (int i = 0; i < gjs_pkg::ORDER; i++)
        begin
            for (int r = i + 1; r < gjs_pkg::ORDER; r++)
            begin
                if (magnitude(matrix[r][i]) > magnitude(matrix[i][i]))
                begin
                    for (int c2 = 0; c2 < gjs_pkg::COLS; c2++)
                    begin
                        tmp = matrix[r][c2];
                        matrix[r][c2] = matrix[i][c2];
                        matrix[i][c2] = tmp;
                    end
                end
            end
            piv = matrix[i][i];
            if (piv == 0)
            begin
                sing = 1'b1;
                continue;
            end
            for (int r = 0; r < gjs_pkg::ORDER; r++)
            begin
                if (r == i)
                    continue;
                factor = matrix[r][i];
                for (int c2 = i; c2 < gjs_pkg::COLS; c2++)
                begin
                    t = scaled_quotient(matrix[i][c2], factor, piv, gjs_pkg::CAP48);
                    matrix[r][c2] = sat_sub48(matrix[r][c2], t);
                end
            end
        end
        for (int k = 0; k < gjs_pkg::ORDER; k++)
            if (matrix[k][k] == 0)
                sing = 1'b1;
        for (int k = 0; k < gjs_pkg::ORDER; k++)
        begin
            d = matrix[k][k];
            s.value = (d == 0) ? 32'sd0 :
                      32'(scaled_quotient(matrix[k][gjs_pkg::ORDER], 65536, d, gjs_pkg::CAP32));
            s.idx = 2'(k);
            s.sing = sing;
            s.last = (k == gjs_pkg::ORDER - 1);
            expected_solutions.insert(expected_solutions.size(), s);
        end
    endtask

    function automatic logic signed [31:0] pick_coeff(input int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return (($urandom_range(0, 3) == 0) ? 32'sd0 : 32'($urandom));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic queue_coeff(input logic signed [31:0] c, input logic sys,
                               input logic drain = 1'b0);
        coeff_item_t it;
        it.coeff = c;
        it.sys = sys;
        it.drain = drain;
        pending_coeffs.insert(pending_coeffs.size(), it);
    endtask

    task automatic queue_system(input int mode, input logic drain = 1'b0);
        for (int n = 0; n < gjs_pkg::CELLS; n++)
            queue_coeff(pick_coeff(mode), n == 0, drain && n == 0);
    endtask

    // Driver: a transfer happens at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                absorb_coeff(coeff_value, start_system);
                void'(pending_coeffs.pop_front());
                coeffs_sent++;
            end
            if (!(start && busy))
            begin
                if (pending_coeffs.size() > 0
                    && !(pending_coeffs[0].drain && expected_solutions.size() != 0)
                    && !((coeffs_sent < 150 || coeffs_sent > 270)
                         && $urandom_range(0, 99) < 18))
                begin
                    start <= 1'b1;
                    coeff_value <= pending_coeffs[0].coeff;
                    start_system <= pending_coeffs[0].sys;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            solutions_seen++;
            if (singular)
                singular_seen_count++;
            if (expected_solutions.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: value %0d index %0d", $time,
                         solution_value, unknown_index);
            end
            else
            begin
                if (solution_value !== expected_solutions[0].value)
                begin
                    errors++;
                    $display("%0t: solution_value expected %0d actual %0d", $time,
                             expected_solutions[0].value, solution_value);
                end
                if (unknown_index !== expected_solutions[0].idx)
                begin
                    errors++;
                    $display("%0t: unknown_index expected %0d actual %0d", $time,
                             expected_solutions[0].idx, unknown_index);
                end
                if (singular !== expected_solutions[0].sing)
                begin
                    errors++;
                    $display("%0t: singular expected %0d actual %0d", $time,
                             expected_solutions[0].sing, singular);
                end
                if (last_result !== expected_solutions[0].last)
                begin
                    errors++;
                    $display("%0t: last_result expected %0d actual %0d", $time,
                             expected_solutions[0].last, last_result);
                end
                void'(expected_solutions.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // Identity with a known right-hand side.
        queue_coeff(32'sh10000, 1'b1);
        queue_coeff(0, 1'b0); queue_coeff(0, 1'b0); queue_coeff(32'sh30000, 1'b0);
        queue_coeff(0, 1'b0); queue_coeff(32'sh10000, 1'b0); queue_coeff(0, 1'b0);
        queue_coeff(-32'sh20000, 1'b0);
        queue_coeff(0, 1'b0); queue_coeff(0, 1'b0); queue_coeff(32'sh10000, 1'b0);
        queue_coeff(32'sh8000, 1'b0);
        // Zero in the first pivot place, equal magnitudes so ties must keep the earlier row,
        // and a missing start that simply follows the last solve.
        queue_coeff(0, 1'b0); queue_coeff(32'sh20000, 1'b0); queue_coeff(32'sh10000, 1'b0);
        queue_coeff(32'sh10000, 1'b0);
        queue_coeff(32'sh20000, 1'b0); queue_coeff(32'sh10000, 1'b0); queue_coeff(0, 1'b0);
        queue_coeff(-32'sh50000, 1'b0);
        queue_coeff(-32'sh20000, 1'b0); queue_coeff(0, 1'b0); queue_coeff(32'sh20000, 1'b0);
        queue_coeff(32'sh7, 1'b0);
        // A partial load abandoned by a new start, then an all-zero singular system.
        queue_coeff(32'sh12345, 1'b1); queue_coeff(-32'sh4321, 1'b0);
        for (int n = 0; n < gjs_pkg::CELLS; n++)
            queue_coeff(0, n == 0);
        // Extreme coefficients drive the saturation paths.
        for (int n = 0; n < gjs_pkg::CELLS; n++)
            queue_coeff((n % 3 == 0) ? 32'sh7fffffff : (n % 3 == 1) ? 32'sh80000000 : 32'sd1,
                        n == 0);
        // Pause the sender until the solver has drained.
        queue_system(0, 1'b1);
        while (pending_coeffs.size() + coeffs_sent < 400)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_coeff(pick_coeff(3), $urandom_range(0, 1));
            else
                queue_system($urandom_range(0, 3));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_coeffs.size() != 0 || expected_solutions.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d coefficients and checked %0d solutions (%0d flagged singular),",
                 coeffs_sent, solutions_seen, singular_seen_count);
        $display("covering pivot swaps, restarts, singular systems and saturation.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
